[hdl/dee_pkg.sv]
// Shared types and constants of the decimal escape decoder.
// Used by every module of the block; depends on nothing.
package dee_pkg;

    // Character codes and the radix of escape digits
    localparam logic [7:0] BACKSLASH_CODE = 8'h5C;
    localparam logic [7:0] DIGIT_ZERO     = 8'h30;
    localparam logic [7:0] DIGIT_NINE     = 8'h39;
    localparam logic [3:0] DECIMAL_BASE   = 4'd10;

    // Default depth of the request queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Request entering the block
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } t_in_item;

    // Request leaving the block
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
    } t_out_item;

    // Work for the back end: one or two decoded bytes from one input request
    typedef struct packed {
        logic       pair;
        logic       last;
        logic [7:0] first;
        logic [7:0] second;
    } t_op;

    // Write side of the queue
    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

endpackage

[hdl/dee_front.sv]
// Front end: escape state machine that classifies each accepted byte
// into zero, one or two decoded bytes. Depends on dee_pkg.
module dee_front import dee_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_ESCAPE,
        PH_ONE_DIGIT,
        PH_TWO_DIGITS
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [6:0] r_value, n_value;

    logic       is_digit;
    logic       is_bs;
    logic [7:0] digit;
    logic [9:0] scaled;
    logic [1:0] cnt;
    logic [7:0] res [2];

    // Decode the incoming byte
    assign is_bs    = (i_item.byte_in == BACKSLASH_CODE);
    assign is_digit = (i_item.byte_in >= DIGIT_ZERO) && (i_item.byte_in <= DIGIT_NINE);
    assign digit    = i_item.byte_in - DIGIT_ZERO;
    assign scaled   = 10'(r_value) * 10'(DECIMAL_BASE) + 10'(digit[3:0]);

    // Advance the escape state and collect the bytes this request yields
    always_comb begin
        n_phase = r_phase;
        n_value = r_value;
        cnt     = 2'd0;
        res[0]  = '0;
        res[1]  = '0;
        unique case (r_phase)
            PH_PLAIN: begin
                if (is_bs) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    res[cnt[0]] = i_item.byte_in;
                    cnt = cnt + 2'd1;
                end
            end
            PH_ESCAPE: begin
                if (is_bs) begin
                    res[cnt[0]] = BACKSLASH_CODE;
                    cnt = cnt + 2'd1;
                    n_phase = PH_PLAIN;
                end else if (is_digit) begin
                    n_value = digit[6:0];
                    n_phase = PH_ONE_DIGIT;
                end else begin
                    // Lone backslash gives a zero byte, then the byte itself
                    res[cnt[0]] = '0;
                    cnt = cnt + 2'd1;
                    res[cnt[0]] = i_item.byte_in;
                    cnt = cnt + 2'd1;
                    n_phase = PH_PLAIN;
                end
            end
            PH_ONE_DIGIT, PH_TWO_DIGITS: begin
                if (is_digit && r_phase == PH_ONE_DIGIT) begin
                    n_value = scaled[6:0];
                    n_phase = PH_TWO_DIGITS;
                end else if (is_digit) begin
                    // Third digit closes the escape, value taken modulo 256
                    res[cnt[0]] = scaled[7:0];
                    cnt = cnt + 2'd1;
                    n_value = '0;
                    n_phase = PH_PLAIN;
                end else begin
                    res[cnt[0]] = 8'(r_value);
                    cnt = cnt + 2'd1;
                    n_value = '0;
                    if (is_bs) begin
                        n_phase = PH_ESCAPE;
                    end else begin
                        res[cnt[0]] = i_item.byte_in;
                        cnt = cnt + 2'd1;
                        n_phase = PH_PLAIN;
                    end
                end
            end
            default: begin
                n_phase = PH_PLAIN;
            end
        endcase

        // Flush a pending escape at the end of the string
        if (i_item.last_in) begin
            if (n_phase == PH_ESCAPE) begin
                res[cnt[0]] = '0;
                cnt = cnt + 2'd1;
            end else if (n_phase != PH_PLAIN) begin
                res[cnt[0]] = 8'(n_value);
                cnt = cnt + 2'd1;
            end
            n_phase = PH_PLAIN;
            n_value = '0;
        end
    end

    // Hand the decoded bytes to the queue
    always_comb begin
        o_push.push      = i_accept && (cnt != 2'd0);
        o_push.op.pair   = (cnt == 2'd2);
        o_push.op.last   = i_item.last_in;
        o_push.op.first  = res[0];
        o_push.op.second = res[1];
    end

    // Hold the escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_value <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_value <= n_value;
        end
    end

    // A string end always leaves the decoder in plain text
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.last_in) |=> (r_phase == PH_PLAIN && r_value == '0))
        else $error("escape state not cleared after last byte");

    // Digit value is only held inside a digit phase
    a_value_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PLAIN || r_phase == PH_ESCAPE) |-> (r_value == '0))
        else $error("digit value left over outside a digit phase");

endmodule

[hdl/dee_queue.sv]
// Short queue of decoded-byte requests between front and back end.
// Depends on dee_pkg for the entry type.
module dee_queue import dee_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_op   o_op,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("push into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

[hdl/dee_back.sv]
// Back end: drains queued requests into the output register, one decoded byte
// per cycle while the receiver does not stall. Depends on dee_pkg.
module dee_back import dee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic      r_valid;
    logic      r_pend;
    t_out_item r_item;
    logic [7:0] r_second;
    logic       r_second_last;
    logic       out_free;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = out_free && !r_pend && !i_empty;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    // Advance output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_op.pair;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output byte and keep the second one of a pair
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_item.byte_out <= r_second;
                r_item.last_out <= r_second_last;
            end else if (!i_empty) begin
                r_item.byte_out <= i_op.first;
                r_item.last_out <= i_op.last && !i_op.pair;
                r_second        <= i_op.second;
                r_second_last   <= i_op.last;
            end
        end
    end

    a_pend_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid)
        else $error("second byte pending with no byte on the output");

endmodule

[hdl/decimal_escape_decoder_unit.sv]
// Top level of the decimal escape decoder: front end, request queue, back end.
// Depends on dee_pkg, dee_front, dee_queue and dee_back.
//
// Usage:
//   Input channel (i_valid, o_stall, i_item) takes one text byte per request,
//   with last_in set on the final byte of a string. Output channel (o_valid,
//   i_stall, o_item) gives decoded bytes, last_out marking the final one.
//   A backslash and up to three decimal digits yield one byte (value mod 256),
//   a double backslash yields one backslash, a lone backslash yields zero.
//   Each decoded byte is registered in the queue and then in the output
//   register before the receiver can take it.
//   Throughput: one input byte per cycle while the queue has room; the output
//   gives one byte per cycle while i_stall is low; the two bytes of a request
//   leave in turn. Sustained rate is set by the single output register.
//   Requests that yield no byte (backslash, escape digits) take no output slot.
//   When the receiver stalls, the output holds and the queue fills; o_stall
//   rises once QUEUE_DEPTH requests wait, and input is refused until one drains.
//   Reset (synchronous, active low) clears the escape state, empties the queue
//   and drops o_valid; no clearing pass is needed.
module decimal_escape_decoder_unit import dee_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_push push;
    t_op   head;
    logic  q_empty;
    logic  q_full;
    logic  pop;
    logic  accept;

    // Refuse input while the queue is full
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    dee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push)
    );

    dee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_op    (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dee_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
